>>> sv/rpl_pkg.sv
// Shared widths, limits and steer codes for the reddest pixel locator.
package rpl_pkg;

    localparam int COLOR_W   = 8;
    localparam int DIST_W    = 18;
    localparam int POS_W     = 11;
    localparam int WIDTH_W   = 12;
    localparam int PROD_W    = 16;

    localparam logic [WIDTH_W-1:0] MAX_COLS    = 12'd2048;
    localparam logic [POS_W-1:0]   ROW_LAST    = 11'd2047;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd640;
    localparam logic [DIST_W-1:0]  DIST_NONE   = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX    = 18'd195075;

    typedef enum logic [1:0] {
        STEER_STRAIGHT = 2'd0,
        STEER_LEFT     = 2'd1,
        STEER_RIGHT    = 2'd2
    } steer_t;

endpackage

>>> sv/reddest_pixel_locator_top.sv
// Reddest pixel locator: per-frame search for the pixel nearest pure red.
//
// Usage: pixels stream in raster order on the s_ channel (valid/ready), one
// beat per pixel with blue, green, red and a last-of-frame flag. Row and
// column come from internal counters that wrap at frame_width (written via
// cfg_wr_en/cfg_wr_data while idle; zero acts as 1, values above 2048 cap).
// On the last beat of a frame one result beat leaves on the m_ channel with
// the winning row, column, its squared distance and a steer code.
// Throughput: one pixel per cycle while s_ready stays high, set by the four-register
// pipe (input, distance, result pending, output).
// Path: a last pixel passes the input, distance and result-pending registers and
// shows its result on m_valid from the output register.
// Stall: while m_ready is low the result holds; earlier stages keep filling
// and non-last pixels keep draining into the search, so s_ready drops only
// when a third last-of-frame beat backs up behind two held results.
// Reset: aresetn (synchronous, active low) empties the pipe, clears the
// search and counters and sets frame_width to 640.
module reddest_pixel_locator_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rpl_pkg::WIDTH_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rpl_pkg::COLOR_W-1:0] s_blue,
    input  logic [rpl_pkg::COLOR_W-1:0] s_green,
    input  logic [rpl_pkg::COLOR_W-1:0] s_red,
    input  logic                        s_last_pixel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rpl_pkg::POS_W-1:0]   m_peak_row,
    output logic [rpl_pkg::POS_W-1:0]   m_peak_col,
    output logic [1:0]                  m_steer,
    output logic [rpl_pkg::DIST_W-1:0]  m_best_distance
);
    import rpl_pkg::*;

    logic [WIDTH_W-1:0] frame_width_reg;
    logic [WIDTH_W-1:0] w_eff;

    // raster position counters
    logic [POS_W-1:0] cur_row_reg, cur_row_next;
    logic [POS_W-1:0] cur_col_reg, cur_col_next;

    // stage 1: input beat
    logic               v1_reg;
    logic [COLOR_W-1:0] blue1_reg, green1_reg, red1_reg;
    logic               last1_reg;
    logic [POS_W-1:0]   row1_reg, col1_reg;

    // stage 2: distance
    logic               v2_reg;
    logic [DIST_W-1:0]  dist2_reg;
    logic               last2_reg;
    logic [POS_W-1:0]   row2_reg, col2_reg;

    // search state
    logic [DIST_W-1:0]  min_dist_reg;
    logic [POS_W-1:0]   best_row_reg, best_col_reg;

    // stage 3: result pending
    logic               v3_reg;
    logic [DIST_W-1:0]  dist3_reg;
    logic [POS_W-1:0]   row3_reg, col3_reg;
    logic [WIDTH_W-1:0] w3_reg;

    // stage 4: output
    logic               v4_reg;
    logic [DIST_W-1:0]  dist4_reg;
    logic [POS_W-1:0]   row4_reg, col4_reg;
    steer_t             steer4_reg, steer_next;

    logic s_fire, ready1, ready2, ready3, ready4;
    logic fire1, fire2, fire3;

    logic [COLOR_W-1:0] dr;
    logic [DIST_W-1:0]  dist_calc;
    logic               better;
    logic [DIST_W-1:0]  win_dist;
    logic [POS_W-1:0]   win_row, win_col;
    logic [PROD_W-1:0]  col_x20, w_x9, w_x11;

    // Handshake chain: each stage frees when its beat moves on.
    assign ready4 = !v4_reg || m_ready;
    assign fire3  = v3_reg && ready4;
    assign ready3 = !v3_reg || ready4;
    assign fire2  = v2_reg && (!last2_reg || ready3);
    assign ready2 = !v2_reg || fire2;
    assign fire1  = v1_reg && ready2;
    assign ready1 = !v1_reg || ready2;
    assign s_ready = ready1;
    assign s_fire  = s_valid && ready1;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (frame_width_reg > MAX_COLS) begin
            w_eff = MAX_COLS;
        end else begin
            w_eff = frame_width_reg;
        end
    end

    always_comb begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        if (s_last_pixel) begin
            cur_row_next = '0;
            cur_col_next = '0;
        end else if ({1'b0, cur_col_reg} + WIDTH_W'(1) >= w_eff) begin
            cur_col_next = '0;
            if (cur_row_reg < ROW_LAST) begin
                cur_row_next = cur_row_reg + POS_W'(1);
            end
        end else begin
            cur_col_next = cur_col_reg + POS_W'(1);
        end
    end

    assign dr        = 8'd255 - red1_reg;
    assign dist_calc = {2'b00, {8'd0, dr} * {8'd0, dr}}
                     + {2'b00, {8'd0, green1_reg} * {8'd0, green1_reg}}
                     + {2'b00, {8'd0, blue1_reg} * {8'd0, blue1_reg}};

    // strict compare keeps the earliest pixel on a tie
    assign better   = dist2_reg < min_dist_reg;
    assign win_dist = better ? dist2_reg : min_dist_reg;
    assign win_row  = better ? row2_reg  : best_row_reg;
    assign win_col  = better ? col2_reg  : best_col_reg;

    assign col_x20 = PROD_W'(col3_reg) * PROD_W'(20);
    assign w_x9    = PROD_W'(w3_reg) * PROD_W'(9);
    assign w_x11   = PROD_W'(w3_reg) * PROD_W'(11);

    always_comb begin
        if (col_x20 < w_x9) begin
            steer_next = STEER_LEFT;
        end else if (col_x20 > w_x11) begin
            steer_next = STEER_RIGHT;
        end else begin
            steer_next = STEER_STRAIGHT;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= WIDTH_RESET;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            min_dist_reg    <= DIST_NONE;
            best_row_reg    <= '0;
            best_col_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                frame_width_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                cur_row_reg <= cur_row_next;
                cur_col_reg <= cur_col_next;
            end
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= fire1;
            end
            if (fire2 && last2_reg) begin
                v3_reg <= 1'b1;
            end else if (fire3) begin
                v3_reg <= 1'b0;
            end
            if (fire3) begin
                v4_reg <= 1'b1;
            end else if (m_ready) begin
                v4_reg <= 1'b0;
            end
            if (fire2) begin
                if (last2_reg) begin
                    min_dist_reg <= DIST_NONE;
                    best_row_reg <= '0;
                    best_col_reg <= '0;
                end else begin
                    min_dist_reg <= win_dist;
                    best_row_reg <= win_row;
                    best_col_reg <= win_col;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            blue1_reg  <= s_blue;
            green1_reg <= s_green;
            red1_reg   <= s_red;
            last1_reg  <= s_last_pixel;
            row1_reg   <= cur_row_reg;
            col1_reg   <= cur_col_reg;
        end
        if (fire1) begin
            dist2_reg <= dist_calc;
            last2_reg <= last1_reg;
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
        end
        if (fire2 && last2_reg) begin
            dist3_reg <= win_dist;
            row3_reg  <= win_row;
            col3_reg  <= win_col;
            w3_reg    <= w_eff;
        end
        if (fire3) begin
            dist4_reg  <= dist3_reg;
            row4_reg   <= row3_reg;
            col4_reg   <= col3_reg;
            steer4_reg <= steer_next;
        end
    end

    assign m_valid         = v4_reg;
    assign m_peak_row      = row4_reg;
    assign m_peak_col      = col4_reg;
    assign m_steer         = steer4_reg;
    assign m_best_distance = dist4_reg;

    a_dist_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_best_distance <= DIST_MAX)
        else $error("result distance above the largest possible");

    a_steer_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_steer != 2'd3))
        else $error("steer code out of range");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v3_reg) |-> $past(v2_reg && last2_reg))
        else $error("pending result without a last-of-frame beat");

    a_last_clears_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_last_pixel) |=> (cur_row_reg == '0 && cur_col_reg == '0))
        else $error("position counters not cleared after last beat");

    a_search_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire2 && last2_reg) |=> (min_dist_reg == DIST_NONE))
        else $error("search not cleared after frame end");

endmodule

>>> tb/tb_reddest_pixel_locator_top.sv
// Self-checking testbench for the reddest pixel locator: random pixel frames against a predictor.
module tb_reddest_pixel_locator_top;
    import rpl_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic               last;
    } pixel_t;

    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        steer_t            steer;
        logic [DIST_W-1:0] sq_dist;
    } winner_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [WIDTH_W-1:0] cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [COLOR_W-1:0] s_blue = '0;
    logic [COLOR_W-1:0] s_green = '0;
    logic [COLOR_W-1:0] s_red = '0;
    logic               s_last_pixel = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [POS_W-1:0]   m_peak_row;
    logic [POS_W-1:0]   m_peak_col;
    logic [1:0]         m_steer;
    logic [DIST_W-1:0]  m_best_distance;

    reddest_pixel_locator_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_blue         (s_blue),
        .s_green        (s_green),
        .s_red          (s_red),
        .s_last_pixel   (s_last_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peak_row     (m_peak_row),
        .m_peak_col     (m_peak_col),
        .m_steer        (m_steer),
        .m_best_distance(m_best_distance)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pixel_t  pixel_q[$];
    winner_t winner_q[$];

    // search state mirrored from the block
    logic [WIDTH_W-1:0] frame_w;
    logic [DIST_W-1:0]  near_dist;
    logic [POS_W-1:0]   near_row;
    logic [POS_W-1:0]   near_col;
    logic [POS_W-1:0]   row_ctr;
    logic [POS_W-1:0]   col_ctr;

    logic        pix_taken = 1'b0;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          fail_cnt = 0;
    int unsigned cycles = 0;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_search();
        near_dist = DIST_NONE;
        near_row  = '0;
        near_col  = '0;
        row_ctr   = '0;
        col_ctr   = '0;
    endtask

    task automatic search_pixel(input pixel_t px);
        int w;
        int d;
        int dr;
        winner_t res;
        w  = (frame_w == '0) ? 1 : ((frame_w > MAX_COLS) ? int'(MAX_COLS) : int'(frame_w));
        dr = 255 - int'(px.red);
        d  = dr * dr + int'(px.green) * int'(px.green) + int'(px.blue) * int'(px.blue);
        if (d < int'(near_dist)) begin
            near_dist = DIST_W'(d);
            near_row  = row_ctr;
            near_col  = col_ctr;
        end
        // a column already past the width wraps too
        if (int'(col_ctr) + 1 >= w) begin
            col_ctr = '0;
            if (row_ctr < ROW_LAST) row_ctr = row_ctr + POS_W'(1);
        end else begin
            col_ctr = col_ctr + POS_W'(1);
        end
        if (px.last) begin
            res.row     = near_row;
            res.col     = near_col;
            res.sq_dist = near_dist;
            if (20 * int'(near_col) < 9 * w) res.steer = STEER_LEFT;
            else if (20 * int'(near_col) > 11 * w) res.steer = STEER_RIGHT;
            else res.steer = STEER_STRAIGHT;
            winner_q.push_back(res);
            clear_search();
        end
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // predictor and result checker
    always @(posedge aclk) begin : watch
        winner_t want;
        pixel_t  px;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end else begin
            pix_taken <= aresetn && s_valid && s_ready;
            if (!aresetn) begin
                frame_w = WIDTH_RESET;
                clear_search();
            end else begin
                if (cfg_wr_en) frame_w = cfg_wr_data;
                if (m_valid && m_ready) begin
                    if (winner_q.size() == 0) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display("%0t: unexpected result beat, expected none, got row %0d col %0d",
                                     $time, m_peak_row, m_peak_col);
                    end else begin
                        want = winner_q.pop_front();
                        check_field("peak_row", want.row, m_peak_row);
                        check_field("peak_col", want.col, m_peak_col);
                        check_field("steer", want.steer, m_steer);
                        check_field("best_distance", want.sq_dist, m_best_distance);
                    end
                end
                if (s_valid && s_ready) begin
                    px = '{s_blue, s_green, s_red, s_last_pixel};
                    search_pixel(px);
                end
            end
        end
    end

    // pixel driver
    always @(negedge aclk) begin : drive_pixels
        pixel_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || pix_taken) begin
            if (tx_gap > 0 || pixel_q.size() == 0) begin
                if (tx_gap > 0) tx_gap--;
                s_valid <= 1'b0;
            end else begin
                nxt = pixel_q.pop_front();
                s_blue       <= nxt.blue;
                s_green      <= nxt.green;
                s_red        <= nxt.red;
                s_last_pixel <= nxt.last;
                s_valid      <= 1'b1;
                tx_gap = pick_gap(tx_idle);
            end
        end
    end

    // result receiver, with a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_gap = pick_gap(rx_idle);
        end
    end

    function automatic pixel_t rand_pixel(int style);
        pixel_t p;
        p.blue  = 8'($urandom);
        p.green = 8'($urandom);
        p.red   = 8'($urandom);
        p.last  = 1'b0;
        if (style == 1) begin
            // close to red, so winners and ties are contested
            p.red   = 8'd255 - 8'($urandom_range(0, 6));
            p.green = 8'($urandom_range(0, 6));
            p.blue  = 8'($urandom_range(0, 6));
        end else if (style == 2) begin
            p.red = 8'($urandom_range(0, 127));
        end
        return p;
    endfunction

    task automatic push_pixel(int b, int g, int r, bit last);
        pixel_q.push_back('{8'(b), 8'(g), 8'(r), last});
    endtask

    task automatic push_frame(int len, bit close);
        pixel_t p;
        p = rand_pixel(0);
        for (int i = 0; i < len; i++) begin
            // sometimes repeat the previous pixel to force a tie
            if ($urandom_range(0, 4) != 0)
                p = rand_pixel(($urandom_range(0, 2) == 0) ? 0 : 1);
            p.last = close && (i == len - 1);
            pixel_q.push_back(p);
        end
    endtask

    // far pixels, then exact red on the last beat
    task automatic push_long_frame(int len);
        for (int i = 0; i < len - 1; i++) pixel_q.push_back(rand_pixel(2));
        push_pixel(0, 0, 255, 1'b1);
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pixel_q.size() != 0 || s_valid || winner_q.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_width(int w);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= WIDTH_W'(w);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int w;
        int n;
        int len;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // reset width: extremes of distance, exact red, tie on exact red
        push_pixel(255, 255, 0, 1'b0);
        push_pixel(0, 0, 0, 1'b0);
        push_pixel(0, 0, 255, 1'b0);
        push_pixel(0, 0, 255, 1'b0);
        push_pixel(255, 255, 255, 1'b1);
        push_pixel(1, 2, 254, 1'b1);
        // leave a frame open at column 4, then shrink the width under it
        push_pixel(200, 100, 10, 1'b0);
        push_pixel(90, 80, 70, 1'b0);
        push_pixel(255, 0, 0, 1'b0);
        push_pixel(0, 255, 128, 1'b0);
        wait_drained();
        write_width(3);
        push_pixel(0, 0, 255, 1'b1);
        // width 3 gives left at columns 0 and 1 and right at column 2
        push_pixel(10, 10, 100, 1'b0);
        push_pixel(0, 1, 255, 1'b0);
        push_pixel(0, 1, 255, 1'b1);
        push_pixel(50, 50, 50, 1'b0);
        push_pixel(40, 50, 50, 1'b0);
        push_pixel(3, 0, 250, 1'b0);
        push_pixel(1, 0, 255, 1'b1);
        wait_drained();
        write_width(0);
        push_pixel(30, 30, 30, 1'b0);
        push_pixel(5, 5, 240, 1'b0);
        push_pixel(6, 5, 240, 1'b1);
        wait_drained();

        // capped width: winner on the last column of a long partial row
        write_width(4095);
        push_long_frame(150);
        wait_drained();
        // width of one: every pixel starts a new row
        write_width(1);
        push_long_frame(150);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            tx_idle = (ph % 3) != 2;
            rx_idle = (ph % 3) != 1;
            case (ph)
                0: w = 2;
                1: w = 20;
                2: w = $urandom_range(1, 40);
                3: w = 2048;
                4: w = 7;
                5: w = $urandom_range(0, 4095);
                6: w = $urandom_range(1, 12);
                default: w = 640;
            endcase
            write_width(w);
            if (ph == 4) begin
                // stall the receiver while short frames keep coming
                tx_idle = 1'b0;
                hold_asked++;
            end
            n = 0;
            while (n < 80) begin
                if (ph == 4) len = $urandom_range(1, 3);
                else if ($urandom_range(0, 9) == 0) len = $urandom_range(30, 80);
                else len = $urandom_range(1, 20);
                push_frame(len, 1'b1);
                n += len;
            end
            // an open frame carries over the next width change
            if (ph % 2 == 1) push_frame($urandom_range(1, 12), 1'b0);
            wait_drained();
        end
        push_frame(5, 1'b1);
        wait_drained();
        repeat (20) @(negedge aclk);

        if (winner_q.size() != 0) begin
            fail_cnt++;
            $display("%0t: %0d results still expected, got none", $time, winner_q.size());
        end
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
